/* src/lmfe_pkg.sv */
package lmfe_pkg;

  // frame geometry
  localparam int unsigned NumRows = 8;
  localparam int unsigned RowW    = 8;
  localparam int unsigned RowIdxW = 3;

  // configuration
  localparam int unsigned  IntensityW   = 4;
  localparam logic [3:0]   IntensityRst = 4'h3;

  // command codes
  typedef enum logic [3:0] {
    KIND_PIXEL    = 4'd0,
    KIND_RECT     = 4'd1,
    KIND_INVERT   = 4'd2,
    KIND_ROTATE   = 4'd3,
    KIND_FILL     = 4'd4,
    KIND_GETPIXEL = 4'd5,
    KIND_WRITEROW = 4'd6,
    KIND_READROW  = 4'd7,
    KIND_REFRESH  = 4'd8,
    KIND_INIT     = 4'd9
  } kind_e;

  // result kinds
  localparam logic RES_WORD  = 1'b0;
  localparam logic RES_REPLY = 1'b1;

  // driver register addresses used by the set-up sequence
  localparam logic [3:0] ADDR_DECODE    = 4'h9;
  localparam logic [3:0] ADDR_INTENSITY = 4'ha;
  localparam logic [3:0] ADDR_SCANLIM   = 4'hb;
  localparam logic [3:0] ADDR_SHUTDOWN  = 4'hc;
  localparam logic [3:0] ADDR_TEST      = 4'hf;
  localparam logic [7:0] SCANLIM_ALL    = 8'h07;
  localparam logic [7:0] SHUTDOWN_RUN   = 8'h01;

  // index of the final beat per emitting command
  localparam logic [2:0] LAST_REFRESH = 3'd7;
  localparam logic [2:0] LAST_INIT    = 3'd4;

endpackage

/* src/led_matrix_frame_engine.sv */
// 8x8 one-bit LED matrix frame engine.
// Commands enter on start with all fields on their own ports; a command is
// taken at a rising edge where start is high and busy is low. busy stays high
// until the command has finished all of its work.
// Frame-changing commands (pixel, rect, invert, rotate, fill, writerow) walk
// the frame one row per cycle with no results; all but rotate go through a
// single row update unit, and rotate loads the transposed frame at row 0.
// Emitting commands send one result beat per cycle on result_valid_o with
// result_kind_o, address_o, data_o and last_o: refresh 8 beats, init 5,
// getpixel and readrow 1. The first beat is registered at the edge after the
// accept edge; busy falls at the edge that registers the last beat, so the
// next command may be taken while that beat is still on the ports.
// So the cost of a command is set by the row walk and the one-beat-per-cycle
// output register.
// The receiver cannot hold results off: each beat is valid for exactly one
// cycle.
// The intensity register is written over cfg_valid_i/cfg_data_i; cfg_ready_o
// is always high. It only affects the data of the intensity set-up beat.
// Reset clears the frame, sets intensity to 3 and returns to idle.
module led_matrix_frame_engine
  import lmfe_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // command channel
  input  logic                  start,
  output logic                  busy,
  input  logic [3:0]            kind_i,
  input  logic signed [7:0]     x_pos_i,
  input  logic signed [7:0]     y_pos_i,
  input  logic [7:0]            rect_width_i,
  input  logic [7:0]            rect_height_i,
  input  logic                  lit_i,
  input  logic [RowIdxW-1:0]    row_index_i,
  input  logic [RowW-1:0]       row_value_i,
  // configuration channel
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [IntensityW-1:0] cfg_data_i,
  // result channel
  output logic                  result_valid_o,
  output logic                  result_kind_o,
  output logic [3:0]            address_o,
  output logic [7:0]            data_o,
  output logic                  last_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROWS,
    ST_EMIT
  } state_e;

  state_e                 state_q;
  logic [RowW-1:0]        frame_q [NumRows];
  logic [IntensityW-1:0]  intensity_q;
  logic [RowIdxW-1:0]     cnt_q;
  logic [2:0]             last_idx_q;
  kind_e                  kind_q;
  logic signed [7:0]      x_q;
  logic signed [7:0]      y_q;
  logic                   lit_q;
  logic [RowIdxW-1:0]     row_index_q;
  logic [RowW-1:0]        row_value_q;
  logic [RowW-1:0]        col_mask_q;
  logic signed [9:0]      y_lo_q;
  logic signed [9:0]      y_hi_q;

  logic                   accept;
  kind_e                  kind_in;
  logic [7:0]             w_in;
  logic [7:0]             h_in;
  logic signed [9:0]      x_lo;
  logic signed [9:0]      x_hi;
  logic signed [9:0]      cpos;
  logic [RowW-1:0]        col_mask_d;
  logic signed [9:0]      rpos;
  logic                   row_hit;
  logic [RowW-1:0]        row_cur;
  logic [RowW-1:0]        row_new;
  logic [RowW-1:0]        rot [NumRows];
  logic                   res_kind;
  logic [3:0]             res_addr;
  logic [7:0]             res_data;
  logic                   res_last;
  logic                   in_range;

  assign accept      = start && !busy;
  assign busy        = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign kind_in     = kind_e'(kind_i);

  // clip window for pixel and rect, columns as a mask
  always_comb begin
    w_in = rect_width_i;
    h_in = rect_height_i;
    if (kind_in == KIND_PIXEL) begin
      w_in = 8'd1;
      h_in = 8'd1;
    end
    x_lo = 10'(x_pos_i);
    x_hi = x_lo + $signed({2'b00, w_in});
    col_mask_d = '0;
    for (int c = 0; c < RowW; c++) begin
      cpos = $signed(10'(c));
      // column 0 is the top bit of a row
      col_mask_d[RowW-1-c] = (cpos >= x_lo) && (cpos < x_hi);
    end
  end

  // row update unit: one row per cycle
  always_comb begin
    row_cur = frame_q[cnt_q];
    rpos    = $signed({7'b0, cnt_q});
    row_hit = (rpos >= y_lo_q) && (rpos < y_hi_q);
    row_new = row_cur;
    unique case (kind_q)
      KIND_PIXEL, KIND_RECT: begin
        if (row_hit) begin
          row_new = lit_q ? (row_cur | col_mask_q) : (row_cur & ~col_mask_q);
        end
      end
      KIND_INVERT: row_new = ~row_cur;
      KIND_FILL:   row_new = lit_q ? '1 : '0;
      KIND_WRITEROW: begin
        if (cnt_q == row_index_q) begin
          row_new = row_value_q;
        end
      end
      default: row_new = row_cur;
    endcase
  end

  // transposed frame for rotate
  always_comb begin
    for (int c = 0; c < NumRows; c++) begin
      for (int r = 0; r < RowW; r++) begin
        rot[c][r] = frame_q[r][RowW-1-c];
      end
    end
  end

  // result beat for the current emit step
  always_comb begin
    in_range = (x_q[7:3] == 5'd0) && (y_q[7:3] == 5'd0);
    res_kind = RES_WORD;
    res_addr = '0;
    res_data = '0;
    res_last = 1'b1;
    unique case (kind_q)
      KIND_REFRESH: begin
        res_addr = {1'b0, cnt_q} + 4'd1;
        res_data = frame_q[cnt_q];
        res_last = (cnt_q == LAST_REFRESH);
      end
      KIND_INIT: begin
        res_last = (cnt_q == LAST_INIT);
        unique case (cnt_q)
          3'd0:    res_addr = ADDR_DECODE;
          3'd1: begin
            res_addr = ADDR_INTENSITY;
            res_data = {4'b0, intensity_q};
          end
          3'd2: begin
            res_addr = ADDR_SCANLIM;
            res_data = SCANLIM_ALL;
          end
          3'd3: begin
            res_addr = ADDR_SHUTDOWN;
            res_data = SHUTDOWN_RUN;
          end
          default: res_addr = ADDR_TEST;
        endcase
      end
      KIND_GETPIXEL: begin
        res_kind = RES_REPLY;
        res_data = {7'b0, in_range && frame_q[y_q[2:0]][RowW-1-int'(x_q[2:0])]};
      end
      KIND_READROW: begin
        res_kind = RES_REPLY;
        res_data = frame_q[row_index_q];
      end
      default: res_kind = RES_WORD;
    endcase
  end

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      intensity_q <= IntensityRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      intensity_q <= cfg_data_i;
    end
  end

  // command latch, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q      <= kind_in;
      x_q         <= x_pos_i;
      y_q         <= y_pos_i;
      lit_q       <= lit_i;
      row_index_q <= row_index_i;
      row_value_q <= row_value_i;
      col_mask_q  <= col_mask_d;
      y_lo_q      <= 10'(y_pos_i);
      y_hi_q      <= 10'(y_pos_i) + $signed({2'b00, h_in});
    end
  end

  // sequencer, frame and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      cnt_q          <= '0;
      last_idx_q     <= '0;
      result_valid_o <= 1'b0;
      result_kind_o  <= 1'b0;
      address_o      <= '0;
      data_o         <= '0;
      last_o         <= 1'b0;
      for (int r = 0; r < NumRows; r++) begin
        frame_q[r] <= '0;
      end
    end else begin
      result_valid_o <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          cnt_q <= '0;
          if (accept) begin
            unique case (kind_in)
              KIND_PIXEL, KIND_RECT, KIND_INVERT, KIND_ROTATE, KIND_FILL,
              KIND_WRITEROW: begin
                state_q <= ST_ROWS;
              end
              KIND_REFRESH: begin
                state_q    <= ST_EMIT;
                last_idx_q <= LAST_REFRESH;
              end
              KIND_INIT: begin
                state_q    <= ST_EMIT;
                last_idx_q <= LAST_INIT;
              end
              KIND_GETPIXEL, KIND_READROW: begin
                state_q    <= ST_EMIT;
                last_idx_q <= '0;
              end
              default: state_q <= ST_IDLE;
            endcase
          end
        end
        ST_ROWS: begin
          if (kind_q == KIND_ROTATE) begin
            if (cnt_q == '0) begin
              for (int r = 0; r < NumRows; r++) begin
                frame_q[r] <= rot[r];
              end
            end
          end else begin
            frame_q[cnt_q] <= row_new;
          end
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == RowIdxW'(NumRows - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_EMIT: begin
          result_valid_o <= 1'b1;
          result_kind_o  <= res_kind;
          address_o      <= res_addr;
          data_o         <= res_data;
          last_o         <= res_last;
          cnt_q          <= cnt_q + 1'b1;
          if (cnt_q == last_idx_q) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

/* test/tb_led_matrix_frame_engine.sv */
module tb_led_matrix_frame_engine
  import lmfe_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // spare command codes that the block must ignore
  localparam logic [3:0] KIND_SPARE_FIRST = 4'd10;
  localparam logic [3:0] KIND_SPARE_LAST  = 4'd15;

  // cycles a frame-changing command may still be busy after the last beat
  localparam int unsigned SettleCycles = 12;
  localparam int unsigned PhaseItems   = 120;

  typedef struct {
    logic [3:0]        kind;
    logic signed [7:0] x_pos;
    logic signed [7:0] y_pos;
    logic [7:0]        rect_width;
    logic [7:0]        rect_height;
    logic              lit;
    logic [2:0]        row_index;
    logic [7:0]        row_value;
  } command_t;

  typedef struct {
    logic       result_kind;
    logic [3:0] address;
    logic [7:0] data;
    logic       last;
  } beat_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  start;
  logic                  busy;
  logic [3:0]            kind_i;
  logic signed [7:0]     x_pos_i;
  logic signed [7:0]     y_pos_i;
  logic [7:0]            rect_width_i;
  logic [7:0]            rect_height_i;
  logic                  lit_i;
  logic [RowIdxW-1:0]    row_index_i;
  logic [RowW-1:0]       row_value_i;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [IntensityW-1:0] cfg_data_i;
  logic                  result_valid_o;
  logic                  result_kind_o;
  logic [3:0]            address_o;
  logic [7:0]            data_o;
  logic                  last_o;

  // predictor state
  logic [RowW-1:0]       frame_model [NumRows];
  logic [IntensityW-1:0] intensity_model;
  beat_t                 expected_beats [$];

  int unsigned errors;
  int unsigned commands_sent;
  int unsigned beats_checked;
  int unsigned intensity_writes;

  led_matrix_frame_engine i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .kind_i         (kind_i),
    .x_pos_i        (x_pos_i),
    .y_pos_i        (y_pos_i),
    .rect_width_i   (rect_width_i),
    .rect_height_i  (rect_height_i),
    .lit_i          (lit_i),
    .row_index_i    (row_index_i),
    .row_value_i    (row_value_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .result_valid_o (result_valid_o),
    .result_kind_o  (result_kind_o),
    .address_o      (address_o),
    .data_o         (data_o),
    .last_o         (last_o)
  );

  // 10 ns clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // run limit
  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic void push_beat(logic rk, logic [3:0] addr, logic [7:0] data,
                                    logic last);
    beat_t b;
    b.result_kind = rk;
    b.address     = addr;
    b.data        = data;
    b.last        = last;
    expected_beats.push_back(b);
  endfunction

  // frame and beat prediction for one accepted command
  function automatic void predict_frame_cmd(command_t c);
    logic [RowW-1:0] rotated [NumRows];
    int x, y, w, h;
    x = int'(c.x_pos);
    y = int'(c.y_pos);
    w = int'(c.rect_width);
    h = int'(c.rect_height);
    case (c.kind)
      KIND_PIXEL: begin
        if (x >= 0 && x <= 7 && y >= 0 && y <= 7) frame_model[y][7-x] = c.lit;
      end
      KIND_RECT: begin
        // only cells inside the matrix can change
        for (int py = 0; py < 8; py++) begin
          for (int px = 0; px < 8; px++) begin
            if (px >= x && px < x + w && py >= y && py < y + h) begin
              frame_model[py][7-px] = c.lit;
            end
          end
        end
      end
      KIND_INVERT: begin
        for (int r = 0; r < 8; r++) frame_model[r] = ~frame_model[r];
      end
      KIND_ROTATE: begin
        // new row c holds column c of the old frame, old row r at bit r
        for (int col = 0; col < 8; col++) begin
          for (int r = 0; r < 8; r++) rotated[col][r] = frame_model[r][7-col];
        end
        for (int r = 0; r < 8; r++) frame_model[r] = rotated[r];
      end
      KIND_FILL: begin
        for (int r = 0; r < 8; r++) frame_model[r] = {RowW{c.lit}};
      end
      KIND_GETPIXEL: begin
        if (x >= 0 && x <= 7 && y >= 0 && y <= 7) begin
          push_beat(RES_REPLY, 4'h0, {7'd0, frame_model[y][7-x]}, 1'b1);
        end else begin
          push_beat(RES_REPLY, 4'h0, 8'h00, 1'b1);
        end
      end
      KIND_WRITEROW: frame_model[c.row_index] = c.row_value;
      KIND_READROW: push_beat(RES_REPLY, 4'h0, frame_model[c.row_index], 1'b1);
      KIND_REFRESH: begin
        for (int r = 0; r < 8; r++) begin
          push_beat(RES_WORD, 4'(r + 1), frame_model[r], r == int'(LAST_REFRESH));
        end
      end
      KIND_INIT: begin
        push_beat(RES_WORD, ADDR_DECODE, 8'h00, 1'b0);
        push_beat(RES_WORD, ADDR_INTENSITY, {4'd0, intensity_model}, 1'b0);
        push_beat(RES_WORD, ADDR_SCANLIM, SCANLIM_ALL, 1'b0);
        push_beat(RES_WORD, ADDR_SHUTDOWN, SHUTDOWN_RUN, 1'b0);
        push_beat(RES_WORD, ADDR_TEST, 8'h00, 1'b1);
      end
      default: ;
    endcase
  endfunction

  function automatic command_t make_cmd(logic [3:0] kind, int x, int y, int w, int h,
                                        bit lit, int ri, int rv);
    command_t c;
    c.kind        = kind;
    c.x_pos       = 8'(x);
    c.y_pos       = 8'(y);
    c.rect_width  = 8'(w);
    c.rect_height = 8'(h);
    c.lit         = lit;
    c.row_index   = 3'(ri);
    c.row_value   = 8'(rv);
    return c;
  endfunction

  // mostly near the matrix, sometimes anywhere in the signed range
  function automatic int rand_coord();
    if ($urandom_range(99) < 75) return int'($urandom_range(9)) - 1;
    return int'($urandom_range(255));
  endfunction

  function automatic int rand_extent();
    if ($urandom_range(99) < 70) return int'($urandom_range(9));
    return int'($urandom_range(255));
  endfunction

  function automatic command_t rand_cmd();
    logic [3:0] kind;
    int unsigned pick;
    pick = $urandom_range(99);
    if      (pick < 20) kind = KIND_PIXEL;
    else if (pick < 34) kind = KIND_RECT;
    else if (pick < 39) kind = KIND_INVERT;
    else if (pick < 46) kind = KIND_ROTATE;
    else if (pick < 50) kind = KIND_FILL;
    else if (pick < 62) kind = KIND_GETPIXEL;
    else if (pick < 72) kind = KIND_WRITEROW;
    else if (pick < 82) kind = KIND_READROW;
    else if (pick < 91) kind = KIND_REFRESH;
    else if (pick < 96) kind = KIND_INIT;
    else kind = 4'($urandom_range(KIND_SPARE_LAST, KIND_SPARE_FIRST));
    return make_cmd(kind, rand_coord(), rand_coord(), rand_extent(), rand_extent(),
                    bit'($urandom_range(1)), int'($urandom_range(7)),
                    int'($urandom_range(255)));
  endfunction

  // one command beat, with random idle cycles before it
  task automatic send_cmd(input command_t c, input int unsigned idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start         <= 1'b1;
    kind_i        <= c.kind;
    x_pos_i       <= c.x_pos;
    y_pos_i       <= c.y_pos;
    rect_width_i  <= c.rect_width;
    rect_height_i <= c.rect_height;
    lit_i         <= c.lit;
    row_index_i   <= c.row_index;
    row_value_i   <= c.row_value;
    do @(posedge clk_i); while (busy);
    predict_frame_cmd(c);
    commands_sent++;
  endtask

  // hold off until every expected beat is in and the block has settled
  task automatic wait_drained();
    start <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_intensity(input logic [IntensityW-1:0] value);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i     <= 1'b0;
    cfg_data_i      <= 4'($urandom_range(15));
    intensity_model  = value;
    intensity_writes++;
  endtask

  // state left by reset: blank frame and default intensity
  task automatic test_after_reset();
    send_cmd(make_cmd(KIND_REFRESH, 0, 0, 0, 0, 0, 0, 0), 0);
    send_cmd(make_cmd(KIND_INIT, 0, 0, 0, 0, 0, 0, 0), 0);
    send_cmd(make_cmd(KIND_READROW, 0, 0, 0, 0, 0, 3, 0), 0);
  endtask

  // single pixels at two corners and off the matrix
  task automatic test_pixel_ops();
    send_cmd(make_cmd(KIND_PIXEL, 0, 0, 0, 0, 1, 0, 0), 0);
    send_cmd(make_cmd(KIND_PIXEL, 7, 7, 0, 0, 1, 0, 0), 0);
    send_cmd(make_cmd(KIND_PIXEL, -1, 3, 0, 0, 1, 0, 0), 0);
    send_cmd(make_cmd(KIND_PIXEL, 127, -128, 0, 0, 1, 0, 0), 0);
    send_cmd(make_cmd(KIND_GETPIXEL, 7, 7, 0, 0, 0, 0, 0), 0);
    send_cmd(make_cmd(KIND_GETPIXEL, 8, 0, 0, 0, 0, 0, 0), 0);
    send_cmd(make_cmd(KIND_GETPIXEL, -128, 127, 0, 0, 0, 0, 0), 0);
  endtask

  // rectangles hanging off every edge, and empty ones
  task automatic test_rect_clipping();
    send_cmd(make_cmd(KIND_RECT, -2, -2, 4, 4, 1, 0, 0), 0);
    send_cmd(make_cmd(KIND_RECT, 2, 2, 0, 5, 1, 0, 0), 0);
    send_cmd(make_cmd(KIND_RECT, 2, 2, 5, 0, 1, 0, 0), 0);
    send_cmd(make_cmd(KIND_RECT, 5, 5, 255, 255, 1, 0, 0), 0);
  endtask

  // whole-frame operations and row access
  task automatic test_frame_ops();
    send_cmd(make_cmd(KIND_WRITEROW, 0, 0, 0, 0, 0, 7, 'hA5), 0);
    send_cmd(make_cmd(KIND_READROW, 0, 0, 0, 0, 0, 7, 0), 0);
    send_cmd(make_cmd(KIND_ROTATE, 0, 0, 0, 0, 0, 0, 0), 0);
    send_cmd(make_cmd(KIND_REFRESH, 0, 0, 0, 0, 0, 0, 0), 0);
    send_cmd(make_cmd(KIND_INVERT, 0, 0, 0, 0, 0, 0, 0), 0);
    send_cmd(make_cmd(KIND_READROW, 0, 0, 0, 0, 0, 0, 0), 0);
    send_cmd(make_cmd(KIND_FILL, 0, 0, 0, 0, 1, 0, 0), 0);
    send_cmd(make_cmd(KIND_INIT, 0, 0, 0, 0, 0, 0, 0), 0);
  endtask

  // spare codes leave the frame alone
  task automatic test_spare_kinds();
    send_cmd(make_cmd(KIND_SPARE_FIRST, 0, 0, 0, 0, 0, 0, 0), 0);
    send_cmd(make_cmd(KIND_SPARE_LAST, 0, 0, 0, 0, 0, 0, 0), 0);
    send_cmd(make_cmd(KIND_REFRESH, 0, 0, 0, 0, 0, 0, 0), 0);
  endtask

  // brightness extremes and a random value, each seen in an init sequence
  task automatic test_intensity_sweep();
    logic [IntensityW-1:0] levels [3];
    levels[0] = '0;
    levels[1] = '1;
    levels[2] = 4'($urandom_range(15));
    foreach (levels[i]) begin
      write_intensity(levels[i]);
      send_cmd(make_cmd(KIND_INIT, 0, 0, 0, 0, 0, 0, 0), 0);
    end
  endtask

  // random command mix; halfway through the sender drains the block
  task automatic test_random_traffic(input int unsigned count, input int unsigned idle_pct);
    for (int unsigned i = 0; i < count; i++) begin
      if (i == count / 2) wait_drained();
      send_cmd(rand_cmd(), idle_pct);
    end
  endtask

  function automatic bit field_ok(string name, logic [7:0] want_v, logic [7:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want_v, got_v);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  // every result beat against the oldest expectation
  always @(posedge clk_i) begin
    beat_t want;
    bit    ok;
    if (rst_ni && result_valid_o) begin
      if (expected_beats.size() == 0) begin
        $display("%0t ns: unexpected beat, expected none, actual kind %0d addr %0h data %0h",
                 $time, result_kind_o, address_o, data_o);
        errors++;
      end else begin
        want = expected_beats.pop_front();
        ok = field_ok("result_kind", 8'(want.result_kind), 8'(result_kind_o))
           & field_ok("address", 8'(want.address), 8'(address_o))
           & field_ok("data", want.data, data_o)
           & field_ok("last", 8'(want.last), 8'(last_o));
        if (!ok) errors++;
        beats_checked++;
      end
    end
  end

  initial begin
    rst_ni        <= 1'b0;
    start         <= 1'b0;
    kind_i        <= KIND_PIXEL;
    x_pos_i       <= '0;
    y_pos_i       <= '0;
    rect_width_i  <= '0;
    rect_height_i <= '0;
    lit_i         <= 1'b0;
    row_index_i   <= '0;
    row_value_i   <= '0;
    cfg_valid_i   <= 1'b0;
    cfg_data_i    <= '0;
    for (int r = 0; r < NumRows; r++) frame_model[r] = '0;
    intensity_model = IntensityRst;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_after_reset();
    test_pixel_ops();
    test_rect_clipping();
    test_frame_ops();
    test_spare_kinds();
    test_intensity_sweep();
    test_random_traffic(PhaseItems, 35);
    write_intensity(4'($urandom_range(15)));
    test_random_traffic(PhaseItems, 61);
    write_intensity(4'($urandom_range(15)));
    test_random_traffic(PhaseItems, 0);

    wait_drained();
    $display("run covered %0d commands of all kinds, %0d result beats checked",
             commands_sent, beats_checked);
    $display("intensity written %0d times, extremes included; %0d errors",
             intensity_writes, errors);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
